FILE: hdl/acf_pkg.sv
// ----------------------------------------------------------------------------
// acf_pkg
// Shared constants, the arctangent table and status types of the
// attitude complementary filter.
// ----------------------------------------------------------------------------
package acf_pkg;

    localparam int CORDIC_STEPS = 16;           // 8 .. 24
    localparam int TAB_LEN      = 24;
    localparam int CNT_W        = 5;            // counts up to 31
    localparam int XW           = 34;           // cordic x/y width
    localparam int ZW           = 26;           // cordic angle width
    localparam int SQ_VW        = 60;           // radicand width
    localparam int SQ_RW        = 30;           // root width
    localparam int SQ_STEPS     = 30;

    localparam logic signed [ZW-1:0] ANGLE_90 = 26'sd5901232;
    localparam logic [16:0]          Q16_ONE  = 17'd65536;

    localparam logic [1:0] REG_BLEND = 2'd0;
    localparam logic [1:0] REG_STEP  = 2'd1;
    localparam logic [1:0] REG_YAW   = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // round(atan(2^-i) * 180/3.14 * 65536)
    function automatic logic [22:0] atan_tab(input logic [CNT_W-1:0] i);
        logic [22:0] v;
        case (i)
            5'd0:    v = 23'd2950616;
            5'd1:    v = 23'd1741850;
            5'd2:    v = 23'd920346;
            5'd3:    v = 23'd467182;
            5'd4:    v = 23'd234498;
            5'd5:    v = 23'd117363;
            5'd6:    v = 23'd58696;
            5'd7:    v = 23'd29350;
            5'd8:    v = 23'd14675;
            5'd9:    v = 23'd7338;
            5'd10:   v = 23'd3669;
            5'd11:   v = 23'd1834;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd459;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            5'd18:   v = 23'd14;
            5'd19:   v = 23'd7;
            5'd20:   v = 23'd4;
            5'd21:   v = 23'd2;
            5'd22:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/acf_if.sv
// ----------------------------------------------------------------------------
// acf channel interfaces
// Sample, result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface acf_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    modport source (output valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
                    input ready);
    modport sink   (input valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
                    output ready);
endinterface

interface acf_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] roll_deg;
    logic signed [31:0] pitch_deg;
    logic signed [31:0] yaw_deg;
    modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
    modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

interface acf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [16:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

FILE: hdl/attitude_complementary_filter_top.sv
// ----------------------------------------------------------------------------
// attitude_complementary_filter_top
// Roll/pitch/yaw complementary filter with a shared multiplier sequencer.
// ----------------------------------------------------------------------------
// One sample beat is taken while the block is idle; it takes no new sample
// until the last one is worked through and its result is pushed to the output
// register. The square root of ay^2+az^2 is the largest share of the work.
// The pitch cordic follows, then four multiplies per axis over six states on
// one 18x33 multiplier. A finished result sits in an output register, so the
// block returns to idle once the previous result beat has left. Register
// writes are always ready.
module attitude_complementary_filter_top
    import acf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    acf_sample_if.sink   i_sample,
    acf_result_if.source o_result,
    acf_cfg_if.sink      i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE, S_SQY, S_SQZ, S_SQD, S_WSQ, S_PIT, S_WPIT,
        S_B0, S_B1, S_B2, S_B3, S_B4, S_B5, S_Y0, S_Y1, S_PUSH
    } t_state;

    t_state               r_state;
    logic signed [15:0]   r_rate [3];
    logic signed [15:0]   r_ax, r_ay, r_az;
    logic [31:0]          r_magsq;
    logic signed [ZW-1:0] r_roll, r_pitch;
    logic                 r_pitch_sel;
    logic [1:0]           r_k;
    logic signed [31:0]   r_p1;
    logic signed [55:0]   r_sum;
    logic signed [50:0]   r_prod;
    logic signed [31:0]   r_est [3];
    logic [16:0]          r_gain;
    logic [15:0]          r_step, r_yawg;
    logic                 r_out_valid;
    logic signed [31:0]   r_out [3];

    logic [16:0]          g, inv_g;
    logic signed [17:0]   mul_a;
    logic signed [32:0]   mul_b;
    logic signed [ZW-1:0] acc_k;
    logic                 cord_start, sq_start;
    logic signed [XW-1:0] cord_y, cord_x;
    logic signed [ZW-1:0] cord_z;
    t_unit_stat           cord_stat, sq_stat;
    logic [31:0]          magsum;
    logic [SQ_RW-1:0]     root;
    logic signed [35:0]   blend_rnd, yaw_sum;
    logic signed [28:0]   yaw_term;
    logic signed [31:0]   blend_sat, yaw_sat;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -36'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    always_comb begin
        g     = (r_gain > Q16_ONE) ? Q16_ONE : r_gain;
        inv_g = Q16_ONE - g;
        unique case (r_k)
            2'd0:    acc_k = r_roll;
            2'd1:    acc_k = r_pitch;
            default: acc_k = '0;
        endcase
        unique case (r_state)
            S_SQY:   begin mul_a = 18'(r_ay); mul_b = 33'(r_ay); end
            S_SQZ:   begin mul_a = 18'(r_az); mul_b = 33'(r_az); end
            S_B0:    begin mul_a = 18'(r_rate[r_k]); mul_b = $signed({17'd0, r_step}); end
            S_B1:    begin mul_a = $signed({1'b0, g}); mul_b = 33'(r_est[r_k]); end
            S_B2:    begin mul_a = $signed({1'b0, g}); mul_b = 33'(r_p1); end
            S_B3:    begin mul_a = $signed({1'b0, inv_g}); mul_b = 33'(acc_k); end
            S_Y0:    begin mul_a = 18'(r_rate[2]); mul_b = $signed({17'd0, r_yawg}); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // roll from (ay, az), pitch from (-ax, |ay,az|), both scaled by 2^14
    always_comb begin
        cord_start = (r_state == S_SQY) || (r_state == S_PIT);
        if (r_state == S_PIT) begin
            cord_y = -$signed({{4{r_ax[15]}}, r_ax, 14'd0});
            cord_x = $signed({{(XW-SQ_RW){1'b0}}, root});
        end else begin
            cord_y = $signed({{4{r_ay[15]}}, r_ay, 14'd0});
            cord_x = $signed({{4{r_az[15]}}, r_az, 14'd0});
        end
        sq_start = (r_state == S_SQD);
        magsum   = r_magsq + r_prod[31:0];
    end

    acf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_y     (cord_y),
        .i_x     (cord_x),
        .o_stat  (cord_stat),
        .o_z     (cord_z)
    );

    acf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value ({magsum, 28'd0}),
        .o_stat  (sq_stat),
        .o_root  (root)
    );

    always_comb begin
        blend_rnd = 36'((r_sum + 56'sd524288) >>> 20);
        blend_sat = sat32(blend_rnd);
        yaw_term  = 29'((r_prod[32:0] + 33'sd8) >>> 4);
        yaw_sum   = 36'(r_est[2]) + 36'(yaw_term);
        yaw_sat   = sat32(yaw_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_pitch_sel <= 1'b0;
            r_out_valid <= 1'b0;
            r_gain      <= 17'd62259;
            r_step      <= 16'd655;
            r_yawg      <= 16'd655;
            r_est[0]    <= '0;
            r_est[1]    <= '0;
            r_est[2]    <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.addr)
                    REG_BLEND: r_gain <= i_cfg.data;
                    REG_STEP:  r_step <= i_cfg.data[15:0];
                    REG_YAW:   r_yawg <= i_cfg.data[15:0];
                    default:   ;
                endcase
            end
            // a push in the same cycle reloads the output register below
            if (r_out_valid && o_result.ready && (r_state != S_PUSH))
                r_out_valid <= 1'b0;
            if (cord_stat.done) begin
                if (r_pitch_sel)
                    r_pitch <= cord_z;
                else
                    r_roll <= cord_z;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_sample.valid) begin
                        r_rate[0] <= i_sample.rate_x;
                        r_rate[1] <= i_sample.rate_y;
                        r_rate[2] <= i_sample.rate_z;
                        r_ax      <= i_sample.accel_x;
                        r_ay      <= i_sample.accel_y;
                        r_az      <= i_sample.accel_z;
                        r_state   <= S_SQY;
                    end
                end
                S_SQY: begin
                    r_pitch_sel <= 1'b0;
                    r_state     <= S_SQZ;
                end
                S_SQZ: begin
                    r_magsq <= r_prod[31:0];
                    r_state <= S_SQD;
                end
                S_SQD: r_state <= S_WSQ;
                S_WSQ: begin
                    if (sq_stat.done)
                        r_state <= S_PIT;
                end
                S_PIT: begin
                    r_pitch_sel <= 1'b1;
                    r_state     <= S_WPIT;
                end
                S_WPIT: begin
                    if (cord_stat.done) begin
                        r_k     <= '0;
                        r_state <= S_B0;
                    end
                end
                S_B0: r_state <= S_B1;
                S_B1: begin
                    r_p1    <= r_prod[31:0];
                    r_state <= S_B2;
                end
                S_B2: begin
                    r_sum   <= 56'(r_prod) <<< 4;
                    r_state <= S_B3;
                end
                S_B3: begin
                    r_sum   <= r_sum + 56'(r_prod);
                    r_state <= S_B4;
                end
                S_B4: begin
                    r_sum   <= r_sum + (56'(r_prod) <<< 4);
                    r_state <= S_B5;
                end
                S_B5: begin
                    r_est[r_k] <= blend_sat;
                    if (r_k == 2'd2) begin
                        r_state <= S_Y0;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_B0;
                    end
                end
                S_Y0: r_state <= S_Y1;
                S_Y1: begin
                    r_est[2] <= yaw_sat;
                    r_state  <= S_PUSH;
                end
                S_PUSH: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid <= 1'b1;
                        r_out[0]    <= r_est[0];
                        r_out[1]    <= r_est[1];
                        r_out[2]    <= r_est[2];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_sample.ready     = (r_state == S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_result.valid     = r_out_valid;
    assign o_result.roll_deg  = r_out[0];
    assign o_result.pitch_deg = r_out[1];
    assign o_result.yaw_deg   = r_out[2];

    a_cord_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_start |-> !cord_stat.busy)
        else $error("cordic restarted while busy");

    a_sq_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |-> !sq_stat.busy)
        else $error("square root restarted while busy");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> !i_sample.ready)
        else $error("sample taken while a sample is in work");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k != 2'd3)
        else $error("axis counter out of range");

endmodule

FILE: hdl/acf_cordic.sv
// ----------------------------------------------------------------------------
// acf_cordic
// Vectoring cordic, one micro-rotation per cycle, angle in signed Q9.16 degrees.
// ----------------------------------------------------------------------------
module acf_cordic
    import acf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [XW-1:0] i_x,
    output t_unit_stat           o_stat,
    output logic signed [ZW-1:0] o_z
);

    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [CNT_W-1:0]     r_i;
    logic                 r_busy, r_done;

    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] tabv;

    always_comb begin
        dx   = r_y >>> r_i;
        dy   = r_x >>> r_i;
        tabv = $signed({{(ZW-23){1'b0}}, atan_tab(r_i)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == CNT_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // fold the left half plane onto the right one
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    r_x <= i_y;
                    r_y <= -i_x;
                    r_z <= ANGLE_90;
                end else begin
                    r_x <= -i_y;
                    r_y <= i_x;
                    r_z <= -ANGLE_90;
                end
            end else begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + tabv;
            end else if (r_y < 0) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - tabv;
            end
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_z    = r_z;

endmodule

FILE: hdl/acf_isqrt.sv
// ----------------------------------------------------------------------------
// acf_isqrt
// Floor integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module acf_isqrt
    import acf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQ_VW-1:0] i_value,
    output t_unit_stat       o_stat,
    output logic [SQ_RW-1:0] o_root
);

    logic [SQ_VW-1:0] r_v, r_r, r_bit;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;

    logic [SQ_VW:0] trial;
    logic           ge;

    always_comb begin
        trial = {1'b0, r_r} + {1'b0, r_bit};
        ge    = {1'b0, r_v} >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(SQ_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= {2'b01, {(SQ_VW-2){1'b0}}};
        end else if (r_busy) begin
            if (ge) begin
                r_v <= r_v - trial[SQ_VW-1:0];
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_root = r_r[SQ_RW-1:0];

endmodule
